/* src/euler_trs_matrix_assert.svh */
//------------------------------------------------------------------------------
// euler_trs_matrix_assert
// Assertion macros for the euler_trs_matrix block.
//------------------------------------------------------------------------------
`ifndef EULER_TRS_MATRIX_ASSERT_SVH
`define EULER_TRS_MATRIX_ASSERT_SVH

// Implication checked at every rising clock edge, outside reset.
`define ETM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ETM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/etm_pkg.sv */
//------------------------------------------------------------------------------
// etm_pkg
// Shared types, constants and sine coefficients for the matrix builder.
//------------------------------------------------------------------------------
package etm_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int Q30                = 30;

    localparam logic [31:0] SIN_C0 = 32'd1686629713;
    localparam logic [31:0] SIN_C1 = 32'd693598668;
    localparam logic [31:0] SIN_C2 = 32'd85569305;
    localparam logic [31:0] SIN_C3 = 32'd5026995;
    localparam logic [31:0] SIN_C4 = 32'd172272;
    localparam logic [31:0] SIN_C5 = 32'd3864;

    // One item as it sits in the queue between the two parts.
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic [31:0]        px;
        logic [31:0]        py;
        logic [31:0]        pz;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
    } etm_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } etm_qstat_t;

endpackage

/* src/euler_trs_matrix.sv */
//------------------------------------------------------------------------------
// euler_trs_matrix
// Scale-rotate-translate matrix builder, Y-X-Z Euler order, one item a cycle when the output does not stall.
//------------------------------------------------------------------------------
// channel   ports                      role
// s_        s_valid/s_ready + fields   transform parameters in
// m_        m_valid/m_ready + fields   matrix entries and translation out
//
// One item per cycle sustained while m_ready is high; after the input transfer an
// item passes the front register, a queue entry and 13 pipe stages to m_valid.
// The sine Horner chain in the back pipeline sets the depth.
// Reset clears only valid flags and the queue's pointers and count; no clearing pass.
// Output stalls freeze the pipe; the queue absorbs the front's item.
module euler_trs_matrix #(
    parameter int ANGLE_BITS     = etm_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_trans_x,
    input  logic signed [31:0] s_trans_y,
    input  logic signed [31:0] s_trans_z,
    input  logic [15:0]        s_angle_x,
    input  logic [15:0]        s_angle_y,
    input  logic [15:0]        s_angle_z,
    input  logic signed [15:0] s_scale_x,
    input  logic signed [15:0] s_scale_y,
    input  logic signed [15:0] s_scale_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_e00,
    output logic signed [15:0] m_e01,
    output logic signed [15:0] m_e02,
    output logic signed [15:0] m_e10,
    output logic signed [15:0] m_e11,
    output logic signed [15:0] m_e12,
    output logic signed [15:0] m_e20,
    output logic signed [15:0] m_e21,
    output logic signed [15:0] m_e22,
    output logic signed [31:0] m_out_tx,
    output logic signed [31:0] m_out_ty,
    output logic signed [31:0] m_out_tz
);
    import etm_pkg::*;
    `include "euler_trs_matrix_assert.svh"

    logic       f_valid, f_ready, q_valid, q_ready;
    etm_item_t  f_item, q_item;
    etm_qstat_t qstat;

    etm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_trans_x, .s_trans_y, .s_trans_z,
        .s_angle_x, .s_angle_y, .s_angle_z,
        .s_scale_x, .s_scale_y, .s_scale_z,
        .f_valid, .f_ready, .f_item
    );

    etm_queue u_queue (
        .aclk, .aresetn,
        .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
        .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item),
        .stat(qstat)
    );

    etm_back #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready,
        .m_e00, .m_e01, .m_e02, .m_e10, .m_e11, .m_e12,
        .m_e20, .m_e21, .m_e22, .m_out_tx, .m_out_ty, .m_out_tz
    );

    `ETM_ASSERT_IMP(a_q_excl, 1'b1, !(qstat.full && qstat.empty), "queue full and empty")
    `ETM_ASSERT_IMP(a_front_q, f_valid && !f_ready, qstat.full, "front stalled, queue not full")
    `ETM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_e00), "output moved")

endmodule

/* src/etm_front.sv */
//------------------------------------------------------------------------------
// etm_front
// Input stage: registers an item and maps angles to 32-bit turn phases.
//------------------------------------------------------------------------------
module etm_front #(
    parameter int ANGLE_BITS = etm_pkg::ANGLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_trans_x,
    input  logic signed [31:0]  s_trans_y,
    input  logic signed [31:0]  s_trans_z,
    input  logic [15:0]         s_angle_x,
    input  logic [15:0]         s_angle_y,
    input  logic [15:0]         s_angle_z,
    input  logic signed [15:0]  s_scale_x,
    input  logic signed [15:0]  s_scale_y,
    input  logic signed [15:0]  s_scale_z,
    output logic                f_valid,
    input  logic                f_ready,
    output etm_pkg::etm_item_t  f_item
);
    import etm_pkg::*;

    localparam logic [31:0] PH_MASK = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);

    logic       valid_reg;
    etm_item_t  item_reg;

    function automatic logic [31:0] phase(input logic [15:0] a);
        phase = {a, 16'h0} & PH_MASK;
    endfunction

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.tx <= s_trans_x;
            item_reg.ty <= s_trans_y;
            item_reg.tz <= s_trans_z;
            item_reg.px <= phase(s_angle_x);
            item_reg.py <= phase(s_angle_y);
            item_reg.pz <= phase(s_angle_z);
            item_reg.sx <= s_scale_x;
            item_reg.sy <= s_scale_y;
            item_reg.sz <= s_scale_z;
        end
    end

endmodule

/* src/etm_queue.sv */
//------------------------------------------------------------------------------
// etm_queue
// Two-entry queue between the front and back parts.
//------------------------------------------------------------------------------
module etm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                w_valid,
    output logic                w_ready,
    input  etm_pkg::etm_item_t  w_item,
    output logic                r_valid,
    input  logic                r_ready,
    output etm_pkg::etm_item_t  r_item,
    output etm_pkg::etm_qstat_t stat
);
    import etm_pkg::*;

    etm_item_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign stat.full  = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;
    assign w_ready = !stat.full;
    assign r_valid = !stat.empty;
    assign r_item  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= w_item;
        end
    end

endmodule

/* src/etm_back.sv */
//------------------------------------------------------------------------------
// etm_back
// Pipelined sine/cosine, products, scaling and saturation.
//------------------------------------------------------------------------------
module etm_back #(
    parameter int TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  etm_pkg::etm_item_t  q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_e00,
    output logic signed [15:0]  m_e01,
    output logic signed [15:0]  m_e02,
    output logic signed [15:0]  m_e10,
    output logic signed [15:0]  m_e11,
    output logic signed [15:0]  m_e12,
    output logic signed [15:0]  m_e20,
    output logic signed [15:0]  m_e21,
    output logic signed [15:0]  m_e22,
    output logic signed [31:0]  m_out_tx,
    output logic signed [31:0]  m_out_ty,
    output logic signed [31:0]  m_out_tz
);
    import etm_pkg::*;

    localparam int F   = TRIG_FRAC_BITS;
    localparam int TW  = F + 2;        // trig value incl. sign and 1.0
    localparam int SW  = TW + 1;       // sum of two products
    localparam int NS  = 13;           // pipeline stages
    localparam int RSH = Q30 - F;

    // stage control
    logic [NS-1:0] v_reg;
    logic          adv;
    assign adv     = !v_reg[NS-1] || m_ready;
    assign q_ready = adv;
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], q_valid};
        end
    end

    // side band carried along the pipe
    logic signed [31:0] tx_reg [NS], ty_reg [NS], tz_reg [NS];
    logic signed [15:0] sx_reg [NS], sy_reg [NS], sz_reg [NS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg[0] <= q_item.tx; ty_reg[0] <= q_item.ty; tz_reg[0] <= q_item.tz;
            sx_reg[0] <= q_item.sx; sy_reg[0] <= q_item.sy; sz_reg[0] <= q_item.sz;
            for (int i = 1; i < NS; i++) begin
                tx_reg[i] <= tx_reg[i-1]; ty_reg[i] <= ty_reg[i-1];
                tz_reg[i] <= tz_reg[i-1]; sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1]; sz_reg[i] <= sz_reg[i-1];
            end
        end
    end

    // six sine lanes: s1,c1 (y), s2,c2 (x), s3,c3 (z); Horner one step per stage
    localparam int L = 6;
    logic [31:0] ph [L];
    assign ph[0] = q_item.py;
    assign ph[1] = q_item.py + 32'h4000_0000;
    assign ph[2] = q_item.px;
    assign ph[3] = q_item.px + 32'h4000_0000;
    assign ph[4] = q_item.pz;
    assign ph[5] = q_item.pz + 32'h4000_0000;

    function automatic logic [31:0] coef(input int k);
        unique case (k)
            0: coef = SIN_C0;
            1: coef = SIN_C1;
            2: coef = SIN_C2;
            3: coef = SIN_C3;
            4: coef = SIN_C4;
            default: coef = SIN_C5;
        endcase
    endfunction

    // stage 0: fold; stage 1: x^2; stages 2..6: Horner; 7: *x; 8: round/sign
    logic [30:0] x_reg  [L][7];
    logic [30:0] x2_reg [L];
    logic [1:0]  qd_reg [L][8];
    logic signed [TW-1:0] trg_reg [L];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                qd_reg[l][0] <= ph[l][31:30];
                x_reg[l][0]  <= ph[l][30] ? (31'h4000_0000 - {1'b0, ph[l][29:0]})
                                          : {1'b0, ph[l][29:0]};
                for (int j = 1; j < 8; j++) qd_reg[l][j] <= qd_reg[l][j-1];
                for (int j = 1; j < 7; j++) x_reg[l][j] <= x_reg[l][j-1];
                x2_reg[l]   <= 31'((62'(x_reg[l][0]) * 62'(x_reg[l][0])) >> Q30);
            end
        end
    end

    // x^2 delayed to line up with each Horner step
    logic [30:0] x2l_reg [L][4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                x2l_reg[l][0] <= x2_reg[l];
                for (int j = 1; j < 4; j++) x2l_reg[l][j] <= x2l_reg[l][j-1];
            end
        end
    end

    logic [31:0] h_reg [L][6];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                h_reg[l][0] <= coef(4)
                    - 32'((63'(SIN_C5) * 63'(x2_reg[l])) >> Q30);
                for (int j = 1; j < 5; j++) begin
                    h_reg[l][j] <= coef(4 - j)
                        - 32'((63'(h_reg[l][j-1]) * 63'(x2l_reg[l][j-1])) >> Q30);
                end
                h_reg[l][5] <= 32'((63'(h_reg[l][4]) * 63'(x_reg[l][6])) >> Q30);
            end
        end
    end

    // stage 8: clamp, round, sign
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                logic [31:0] c;
                logic [31:0] r;
                c = (h_reg[l][5] > 32'h4000_0000) ? 32'h4000_0000 : h_reg[l][5];
                r = (c + (32'h1 << (RSH - 1))) >> RSH;
                trg_reg[l] <= qd_reg[l][7][1] ? -$signed(TW'(r)) : $signed(TW'(r));
            end
        end
    end

    function automatic logic signed [TW-1:0] tm(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
        logic [TW-1:0]   ma, mb;
        logic [2*TW-1:0] m;
        logic [TW-1:0]   r;
        ma = a[TW-1] ? TW'(-a) : a;
        mb = b[TW-1] ? TW'(-b) : b;
        m  = (2*TW)'(ma) * (2*TW)'(mb) + ((2*TW)'(1) << (F - 1));
        r  = TW'(m >> F);
        tm = (a[TW-1] ^ b[TW-1]) ? -$signed(r) : $signed(r);
    endfunction

    // stage 9: pair products
    logic signed [TW-1:0] c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [TW-1:0] c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    logic signed [TW-1:0] s2_reg, s3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            c1c3_reg <= tm(trg_reg[1], trg_reg[5]);
            s1s2_reg <= tm(trg_reg[0], trg_reg[2]);
            c2s3_reg <= tm(trg_reg[3], trg_reg[4]);
            c1s2_reg <= tm(trg_reg[1], trg_reg[2]);
            c3s1_reg <= tm(trg_reg[5], trg_reg[0]);
            c1s3_reg <= tm(trg_reg[1], trg_reg[4]);
            c2c3_reg <= tm(trg_reg[3], trg_reg[5]);
            s1s3_reg <= tm(trg_reg[0], trg_reg[4]);
            c2s1_reg <= tm(trg_reg[3], trg_reg[0]);
            c1c2_reg <= tm(trg_reg[1], trg_reg[3]);
            s2_reg   <= trg_reg[2];
            s3_reg   <= trg_reg[4];
        end
    end

    // stage 10: triple products, carry pairs
    logic signed [TW-1:0] t0_reg, t2_reg, t3_reg, t5_reg;
    logic signed [TW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p8_reg;
    logic signed [TW-1:0] ns2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg <= tm(s1s2_reg, s3_reg);
            t2_reg <= tm(c1s2_reg, s3_reg);
            t3_reg <= tm(c3s1_reg, s2_reg);
            t5_reg <= tm(c1c3_reg, s2_reg);
            p0_reg <= c1c3_reg; p1_reg <= c2s3_reg; p2_reg <= c3s1_reg; p3_reg <= c1s3_reg;
            p4_reg <= c2c3_reg; p5_reg <= s1s3_reg; p6_reg <= c2s1_reg; p8_reg <= c1c2_reg;
            ns2_reg <= -s2_reg;
        end
    end

    // stage 11: sums
    logic signed [SW-1:0] r_reg [9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg[0] <= SW'(p0_reg) + SW'(t0_reg);
            r_reg[1] <= SW'(p1_reg);
            r_reg[2] <= SW'(t2_reg) - SW'(p2_reg);
            r_reg[3] <= SW'(t3_reg) - SW'(p3_reg);
            r_reg[4] <= SW'(p4_reg);
            r_reg[5] <= SW'(t5_reg) + SW'(p5_reg);
            r_reg[6] <= SW'(p6_reg);
            r_reg[7] <= SW'(ns2_reg);
            r_reg[8] <= SW'(p8_reg);
        end
    end

    // stage 12: scale, round, saturate
    localparam int PW = SW + 16;
    function automatic logic signed [15:0] ent(input logic signed [15:0] s,
                                                input logic signed [SW-1:0] r);
        logic [15:0] ms;
        logic [SW-1:0] mr;
        logic [PW-1:0] m;
        logic [PW-1:0] q;
        logic neg;
        neg = s[15] ^ r[SW-1];
        ms = s[15] ? 16'(-s) : s;
        mr = r[SW-1] ? SW'(-r) : r;
        m  = PW'(ms) * PW'(mr) + (PW'(1) << (F - 1));
        q  = m >> F;
        if (neg) ent = (q > PW'(32768)) ? -16'sd32768 : 16'(-q);
        else     ent = (q > PW'(32767)) ? 16'sd32767 : 16'(q);
    endfunction

    logic signed [15:0] e_reg [9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                e_reg[i] <= ent(i < 3 ? sx_reg[11] : (i < 6 ? sy_reg[11] : sz_reg[11]),
                                r_reg[i]);
            end
        end
    end

    assign m_e00 = e_reg[0]; assign m_e01 = e_reg[1]; assign m_e02 = e_reg[2];
    assign m_e10 = e_reg[3]; assign m_e11 = e_reg[4]; assign m_e12 = e_reg[5];
    assign m_e20 = e_reg[6]; assign m_e21 = e_reg[7]; assign m_e22 = e_reg[8];
    assign m_out_tx = tx_reg[NS-1];
    assign m_out_ty = ty_reg[NS-1];
    assign m_out_tz = tz_reg[NS-1];

endmodule
